// ===== design/pac_pkg.sv =====
// shared types, codes and tables of the pose agreement confirmer
`default_nettype none
package pac_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_W          = 36;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [1:0] FUNC_QUERY  = 2'd0;
  localparam logic [1:0] FUNC_INGEST = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] OUT_PENDING   = 2'd0;
  localparam logic [1:0] OUT_CONFIRMED = 2'd1;
  localparam logic [1:0] OUT_TIMEOUT   = 2'd2;
  localparam logic [1:0] OUT_SKIPPED   = 2'd3;

  localparam logic [2:0] REG_FRAMES    = 3'd0;
  localparam logic [2:0] REG_XY_TOL    = 3'd1;
  localparam logic [2:0] REG_YAW_TOL   = 3'd2;
  localparam logic [2:0] REG_PERIOD    = 3'd3;
  localparam logic [2:0] REG_WINDOW    = 3'd4;

  localparam int CFG_DATA_W = 40;

  typedef enum logic [1:0] {
    KIND_QUERY,
    KIND_INGEST,
    KIND_CLEAR,
    KIND_NONE
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CORDIC,
    BK_AGREE,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic [15:0] frames_needed;
    logic [30:0] xy_tolerance;
    logic [14:0] yaw_tolerance;
    logic [39:0] probe_period_ns;
    logic [39:0] attempt_window_ns;
  } settings_t;

  typedef struct packed {
    kind_t                       kind;
    logic                        gates;
    logic [62:0]                 now_ns;
    logic [1:0]                  clock_kind;
    logic signed [31:0]          pos_x;
    logic signed [31:0]          pos_y;
    logic signed [CORDIC_W-1:0]  vec_x;
    logic signed [CORDIC_W-1:0]  vec_y;
    logic                        half_turn;
    logic                        rot_zero;
  } item_t;

  typedef struct packed {
    logic load;
    logic run;
    logic check;
    logic commit;
  } back_ctl_t;

  // atan(2^-i) in 2^32 units per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/pose_agreement_confirmer.sv =====
// Pose agreement confirmer: counts runs of agreeing pose probes and answers
// confirmed, timeout or pending; also answers probe-due queries and clears.
// A transaction is taken whenever the four-entry input queue has room, so the
// input side keeps moving while the back end works and a result waits in the
// output register. The back end handles one transaction at a time: a query, a
// clear, an unused code or a rejected ingest goes from idle to done; an ingest
// that passes its gates under valid settings also runs the iterative cordic,
// which derives yaw one stage per cycle, and the agreement check before done.
// Configuration registers are written through cfg_write, cfg_index and cfg_data
// and are meant to change only while the block is idle.
`default_nettype none
module pose_agreement_confirmer #(
  parameter int ANGLE_BITS    = pac_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = pac_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_stall,
  input  wire logic [1:0]                     func,
  input  wire logic [62:0]                    now_ns,
  input  wire logic [1:0]                     clock_kind,
  input  wire logic                           status_pending,
  input  wire logic                           pose_finite,
  input  wire logic signed [31:0]             pos_x,
  input  wire logic signed [31:0]             pos_y,
  input  wire logic signed [15:0]             rot_cos,
  input  wire logic signed [15:0]             rot_sin,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output logic [1:0]                          outcome,
  output logic                                probe_due,
  output logic [31:0]                         probes_seen,
  output logic [15:0]                         agreements,
  input  wire logic                           cfg_write,
  input  wire logic [2:0]                     cfg_index,
  input  wire logic [pac_pkg::CFG_DATA_W-1:0] cfg_data
);

  pac_pkg::settings_t settings;
  pac_pkg::item_t     front_item;
  pac_pkg::item_t     head;
  logic               full;
  logic               empty;
  logic               pop;
  logic               push;

  always_ff @(posedge clk) begin
    if (rst) begin
      settings.frames_needed     <= 16'd3;
      settings.xy_tolerance      <= 31'd16384;
      settings.yaw_tolerance     <= 15'd910;
      settings.probe_period_ns   <= 40'd1000000000;
      settings.attempt_window_ns <= 40'd10000000000;
    end else if (cfg_write) begin
      case (cfg_index)
        pac_pkg::REG_FRAMES:  settings.frames_needed     <= cfg_data[15:0];
        pac_pkg::REG_XY_TOL:  settings.xy_tolerance      <= cfg_data[30:0];
        pac_pkg::REG_YAW_TOL: settings.yaw_tolerance     <= cfg_data[14:0];
        pac_pkg::REG_PERIOD:  settings.probe_period_ns   <= cfg_data[39:0];
        pac_pkg::REG_WINDOW:  settings.attempt_window_ns <= cfg_data[39:0];
        default: begin
        end
      endcase
    end
  end

  assign item_stall = full;
  assign push       = item_valid && !full;

  pac_front u_front (
    .func           (func),
    .now_ns         (now_ns),
    .clock_kind     (clock_kind),
    .status_pending (status_pending),
    .pose_finite    (pose_finite),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .rot_cos        (rot_cos),
    .rot_sin        (rot_sin),
    .item           (front_item)
  );

  pac_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  pac_back #(
    .ANGLE_BITS    (ANGLE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (settings),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .outcome      (outcome),
    .probe_due    (probe_due),
    .probes_seen  (probes_seen),
    .agreements   (agreements)
  );

endmodule
`default_nettype wire

// ===== design/pac_front.sv =====
// front end: classifies an incoming transaction and prepares the cordic start vector
`default_nettype none
module pac_front (
  input  wire logic [1:0]         func,
  input  wire logic [62:0]        now_ns,
  input  wire logic [1:0]         clock_kind,
  input  wire logic               status_pending,
  input  wire logic               pose_finite,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [15:0] rot_cos,
  input  wire logic signed [15:0] rot_sin,
  output pac_pkg::item_t          item
);

  logic signed [pac_pkg::CORDIC_W-1:0] cx;
  logic signed [pac_pkg::CORDIC_W-1:0] cy;
  pac_pkg::kind_t                      kind;

  assign cx = {{(pac_pkg::CORDIC_W-32){rot_cos[15]}}, rot_cos, 16'h0000};
  assign cy = {{(pac_pkg::CORDIC_W-32){rot_sin[15]}}, rot_sin, 16'h0000};

  always_comb begin
    case (func)
      pac_pkg::FUNC_QUERY:  kind = pac_pkg::KIND_QUERY;
      pac_pkg::FUNC_INGEST: kind = pac_pkg::KIND_INGEST;
      pac_pkg::FUNC_CLEAR:  kind = pac_pkg::KIND_CLEAR;
      default:              kind = pac_pkg::KIND_NONE;
    endcase
  end

  always_comb begin
    item.kind       = kind;
    item.gates      = status_pending & pose_finite;
    item.now_ns     = now_ns;
    item.clock_kind = clock_kind;
    item.pos_x      = pos_x;
    item.pos_y      = pos_y;
    // left half plane: turn by a half turn first
    item.half_turn  = rot_cos[15];
    item.vec_x      = rot_cos[15] ? -cx : cx;
    item.vec_y      = rot_cos[15] ? -cy : cy;
    item.rot_zero   = (rot_cos == 16'sd0) && (rot_sin == 16'sd0);
  end

endmodule
`default_nettype wire

// ===== design/pac_queue.sv =====
// short queue between the front end and the back end
`default_nettype none
module pac_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire pac_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output pac_pkg::item_t      head,
  output logic                empty
);

  localparam int PW = $clog2(pac_pkg::QUEUE_DEPTH);

  pac_pkg::item_t mem [pac_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;

  assign full  = (count == (PW+1)'(pac_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/pac_back.sv =====
// back end: cordic yaw, pose agreement check, state update and result register
`default_nettype none
module pac_back #(
  parameter int ANGLE_BITS    = pac_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = pac_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pac_pkg::settings_t cfg,
  input  wire pac_pkg::item_t     head,
  input  wire logic               empty,
  output logic                    pop,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic [1:0]              outcome,
  output logic                    probe_due,
  output logic [31:0]             probes_seen,
  output logic [15:0]             agreements
);

  localparam int SW = $clog2(CORDIC_STAGES);
  localparam int CW = pac_pkg::CORDIC_W;

  pac_pkg::back_state_t state, state_next;
  pac_pkg::back_ctl_t   ctl;
  pac_pkg::item_t       cur;

  // block state
  logic [31:0]           probe_total;
  logic [15:0]           agree_run;
  logic                  holds_pose;
  logic signed [31:0]    held_x;
  logic signed [31:0]    held_y;
  logic [ANGLE_BITS-1:0] held_yaw;
  logic [62:0]           first_stamp;
  logic [1:0]            first_clock;
  logic [62:0]           latest_stamp;
  logic [1:0]            latest_clock;

  // working registers
  logic signed [CW-1:0]  cx;
  logic signed [CW-1:0]  cy;
  logic [31:0]           acc;
  logic [SW-1:0]         cnt;
  logic [32:0]           ax;
  logic [32:0]           ay;
  logic [61:0]           sq_x;
  logic [61:0]           sq_y;
  logic [61:0]           sq_t;
  logic                  agree;
  logic [ANGLE_BITS-1:0] yaw_new;

  logic settings_ok;
  logic out_free;
  logic last_stage;

  assign settings_ok = (|cfg.frames_needed) && (|cfg.xy_tolerance) &&
                       (|cfg.yaw_tolerance) && (|cfg.probe_period_ns) &&
                       (|cfg.attempt_window_ns);
  assign out_free    = !result_valid || !result_stall;
  assign last_stage  = (cnt == SW'(CORDIC_STAGES - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pac_pkg::BK_IDLE: begin
        if (!empty) begin
          if (head.kind == pac_pkg::KIND_INGEST && head.gates && settings_ok) begin
            state_next = pac_pkg::BK_CORDIC;
          end else begin
            state_next = pac_pkg::BK_DONE;
          end
        end
      end
      pac_pkg::BK_CORDIC: begin
        if (last_stage) begin
          state_next = pac_pkg::BK_AGREE;
        end
      end
      pac_pkg::BK_AGREE: state_next = pac_pkg::BK_DONE;
      pac_pkg::BK_DONE: begin
        if (out_free) begin
          state_next = pac_pkg::BK_IDLE;
        end
      end
      default: state_next = pac_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl.load   = (state == pac_pkg::BK_IDLE) && !empty;
    ctl.run    = (state == pac_pkg::BK_CORDIC);
    ctl.check  = (state == pac_pkg::BK_AGREE);
    ctl.commit = (state == pac_pkg::BK_DONE) && out_free;
  end

  assign pop = ctl.load;

  // load: position differences against the held pose
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  assign dx = {held_x[31], held_x} - {head.pos_x[31], head.pos_x};
  assign dy = {held_y[31], held_y} - {head.pos_y[31], head.pos_y};

  // one cordic vectoring stage
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic [31:0]          atan_v;
  assign xs     = cx >>> cnt;
  assign ys     = cy >>> cnt;
  assign atan_v = pac_pkg::atan_turn(5'(cnt));

  // shared squarer: squares ax, then ay, then the xy tolerance while the cordic runs
  logic [30:0] mul_a;
  logic [61:0] mul_p;
  always_comb begin
    if (cnt == SW'(0)) begin
      mul_a = ax[30:0];
    end else if (cnt == SW'(1)) begin
      mul_a = ay[30:0];
    end else begin
      mul_a = cfg.xy_tolerance;
    end
  end
  assign mul_p = mul_a * mul_a;

  // agreement check
  logic [31:0]           acc_r;
  logic [ANGLE_BITS-1:0] yaw_c;
  logic [ANGLE_BITS-1:0] yaw_d;
  logic [ANGLE_BITS-1:0] yaw_f;
  logic                  coarse_ok;
  logic                  fine_ok;
  logic                  yaw_ok;
  assign acc_r     = acc + (32'd1 << (31 - ANGLE_BITS));
  assign yaw_c     = cur.rot_zero ? '0 : acc_r[31 -: ANGLE_BITS];
  assign yaw_d     = yaw_c - held_yaw;
  // fold to the shorter way around
  assign yaw_f     = (yaw_d > (ANGLE_BITS'(1) << (ANGLE_BITS - 1))) ? -yaw_d : yaw_d;
  assign yaw_ok    = (32'(yaw_f) <= 32'(cfg.yaw_tolerance));
  assign coarse_ok = (ax <= 33'(cfg.xy_tolerance)) && (ay <= 33'(cfg.xy_tolerance));
  assign fine_ok   = ((63'(sq_x) + 63'(sq_y)) <= 63'(sq_t));

  // commit values
  logic        ingest_ok;
  logic [31:0] total_inc;
  logic [15:0] run_inc;
  logic [15:0] run_new;
  logic        take_first;
  logic [62:0] first_new;
  logic [1:0]  first_clk_new;
  logic [62:0] since_first;
  logic        timed_out;
  logic [62:0] since_latest;
  logic        due;
  logic [1:0]  ingest_outcome;

  assign ingest_ok     = (cur.kind == pac_pkg::KIND_INGEST) && settings_ok;
  assign total_inc     = (probe_total == 32'hFFFF_FFFF) ? probe_total : probe_total + 32'd1;
  assign run_inc       = (agree_run == 16'hFFFF) ? agree_run : agree_run + 16'd1;
  assign run_new       = !cur.gates ? 16'd0 : (agree ? run_inc : 16'd1);
  assign take_first    = (first_stamp == 63'd0) || (cur.clock_kind != first_clock);
  assign first_new     = take_first ? cur.now_ns : first_stamp;
  assign first_clk_new = take_first ? cur.clock_kind : first_clock;
  assign since_first   = cur.now_ns - first_new;
  assign timed_out     = (cur.clock_kind == first_clk_new) && (cur.now_ns > first_new) &&
                         (since_first > 63'(cfg.attempt_window_ns));
  assign since_latest  = cur.now_ns - latest_stamp;
  assign due           = settings_ok && (cur.now_ns != 63'd0) &&
                         ((latest_stamp == 63'd0) || (cur.clock_kind != latest_clock) ||
                          (cur.now_ns < latest_stamp) ||
                          (since_latest >= 63'(cfg.probe_period_ns)));

  always_comb begin
    if (run_new >= cfg.frames_needed) begin
      ingest_outcome = pac_pkg::OUT_CONFIRMED;
    end else if (timed_out) begin
      ingest_outcome = pac_pkg::OUT_TIMEOUT;
    end else begin
      ingest_outcome = pac_pkg::OUT_PENDING;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cur <= head;
      cx  <= head.vec_x;
      cy  <= head.vec_y;
      acc <= {head.half_turn, 31'd0};
      cnt <= '0;
      ax  <= dx[32] ? 33'(-dx) : 33'(dx);
      ay  <= dy[32] ? 33'(-dy) : 33'(dy);
    end
    if (ctl.run) begin
      if (!cy[CW-1]) begin
        cx  <= cx + ys;
        cy  <= cy - xs;
        acc <= acc + atan_v;
      end else begin
        cx  <= cx - ys;
        cy  <= cy + xs;
        acc <= acc - atan_v;
      end
      cnt <= cnt + SW'(1);
      if (cnt == SW'(0)) begin
        sq_x <= mul_p;
      end
      if (cnt == SW'(1)) begin
        sq_y <= mul_p;
      end
      if (cnt == SW'(2)) begin
        sq_t <= mul_p;
      end
    end
    if (ctl.check) begin
      agree   <= holds_pose && coarse_ok && fine_ok && yaw_ok;
      yaw_new <= yaw_c;
    end
  end

  // state machine, block state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pac_pkg::BK_IDLE;
      result_valid <= 1'b0;
      probe_total  <= '0;
      agree_run    <= '0;
      holds_pose   <= 1'b0;
      held_x       <= '0;
      held_y       <= '0;
      held_yaw     <= '0;
      first_stamp  <= '0;
      first_clock  <= '0;
      latest_stamp <= '0;
      latest_clock <= '0;
    end else begin
      state <= state_next;
      if (ctl.commit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (ctl.commit) begin
        case (cur.kind)
          pac_pkg::KIND_INGEST: begin
            if (settings_ok) begin
              probe_total  <= total_inc;
              first_stamp  <= first_new;
              first_clock  <= first_clk_new;
              latest_stamp <= cur.now_ns;
              latest_clock <= cur.clock_kind;
              agree_run    <= run_new;
              holds_pose   <= cur.gates;
              if (cur.gates) begin
                held_x   <= cur.pos_x;
                held_y   <= cur.pos_y;
                held_yaw <= yaw_new;
              end
            end
          end
          pac_pkg::KIND_CLEAR: begin
            probe_total  <= '0;
            agree_run    <= '0;
            holds_pose   <= 1'b0;
            held_x       <= '0;
            held_y       <= '0;
            held_yaw     <= '0;
            first_stamp  <= '0;
            first_clock  <= '0;
            latest_stamp <= '0;
            latest_clock <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      case (cur.kind)
        pac_pkg::KIND_QUERY: begin
          outcome     <= pac_pkg::OUT_SKIPPED;
          probe_due   <= due;
          probes_seen <= probe_total;
          agreements  <= agree_run;
        end
        pac_pkg::KIND_INGEST: begin
          outcome     <= ingest_ok ? ingest_outcome : pac_pkg::OUT_SKIPPED;
          probe_due   <= 1'b0;
          probes_seen <= ingest_ok ? total_inc : probe_total;
          agreements  <= ingest_ok ? run_new : agree_run;
        end
        pac_pkg::KIND_CLEAR: begin
          outcome     <= pac_pkg::OUT_SKIPPED;
          probe_due   <= 1'b0;
          probes_seen <= '0;
          agreements  <= '0;
        end
        default: begin
          outcome     <= pac_pkg::OUT_SKIPPED;
          probe_due   <= 1'b0;
          probes_seen <= probe_total;
          agreements  <= agree_run;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== verif/pose_agreement_confirmer_tb.sv =====
// self-checking testbench of the pose agreement confirmer: directed table, then randomized phases
module pose_agreement_confirmer_tb;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [2:0] REG_SPARE = 3'd5;
  localparam int SETTLE_CYCLES = pac_pkg::CORDIC_STAGES_DEF + 8;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 183;
  localparam logic [39:0] REG40_MAX = 40'hFF_FFFF_FFFF;
  localparam int REG_WIDTH [5] = '{16, 31, 15, 40, 40};

  // arctangent of 2^-i in 2^32 units per turn
  localparam logic [31:0] ARCTAN_STEP [16] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
    32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
    32'd166886, 32'd83443, 32'd41722, 32'd20861};

  typedef struct packed {
    logic [1:0]         func;
    logic [62:0]        now_ns;
    logic [1:0]         clock_kind;
    logic               status_pending;
    logic               pose_finite;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] rot_cos;
    logic signed [15:0] rot_sin;
  } pose_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic        due;
    logic [31:0] seen;
    logic [15:0] run;
  } verdict_t;

  typedef struct packed {
    pose_item_t stim;
    logic       typed;
    verdict_t   want;
  } row_t;

  localparam row_t PLAN [25] = '{
    // time unset, then nothing stamped yet, then an unused code
    '{'{pac_pkg::FUNC_QUERY, 63'd0, 2'd0, 1'b0, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0},
      1'b1, '{pac_pkg::OUT_SKIPPED, 1'b0, 32'd0, 16'd0}},
    '{'{pac_pkg::FUNC_QUERY, 63'd100, 2'd0, 1'b0, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0},
      1'b1, '{pac_pkg::OUT_SKIPPED, 1'b1, 32'd0, 16'd0}},
    '{'{FUNC_UNUSED, 63'd5, 2'd1, 1'b1, 1'b1, 32'sd1, 32'sd1, 16'sd1, 16'sd1},
      1'b1, '{pac_pkg::OUT_SKIPPED, 1'b0, 32'd0, 16'd0}},
    '{'{pac_pkg::FUNC_INGEST, 63'd1000, 2'd0, 1'b1, 1'b1, 32'sd0, 32'sd0, 16'sd32767, 16'sd0},
      1'b1, '{pac_pkg::OUT_PENDING, 1'b0, 32'd1, 16'd1}},
    // period not yet passed, exactly passed, other clock, time went backwards
    '{'{pac_pkg::FUNC_QUERY, 63'd500001000, 2'd0, 1'b0, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0},
      1'b1, '{pac_pkg::OUT_SKIPPED, 1'b0, 32'd1, 16'd1}},
    '{'{pac_pkg::FUNC_QUERY, 63'd1000001000, 2'd0, 1'b0, 1'b0, 32'sd0, 32'sd0, 16'sd0,
        16'sd0}, 1'b1, '{pac_pkg::OUT_SKIPPED, 1'b1, 32'd1, 16'd1}},
    '{'{pac_pkg::FUNC_QUERY, 63'd1000, 2'd2, 1'b0, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0},
      1'b1, '{pac_pkg::OUT_SKIPPED, 1'b1, 32'd1, 16'd1}},
    '{'{pac_pkg::FUNC_QUERY, 63'd999, 2'd0, 1'b0, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0},
      1'b1, '{pac_pkg::OUT_SKIPPED, 1'b1, 32'd1, 16'd1}},
    // distance right on the tolerance radius, then confirmation
    '{'{pac_pkg::FUNC_INGEST, 63'd2000, 2'd0, 1'b1, 1'b1, 32'sd16384, 32'sd0,
        16'sd32767, 16'sd0}, 1'b0, '0},
    '{'{pac_pkg::FUNC_INGEST, 63'd3000, 2'd0, 1'b1, 1'b1, 32'sd16384, 32'sd16384,
        16'sd32767, 16'sd0}, 1'b1, '{pac_pkg::OUT_CONFIRMED, 1'b0, 32'd3, 16'd3}},
    '{'{pac_pkg::FUNC_INGEST, 63'd4000, 2'd0, 1'b1, 1'b1, 32'sd16384, 32'sd16384,
        16'sd32767, 16'sd300}, 1'b0, '0},
    '{'{pac_pkg::FUNC_INGEST, 63'd5000, 2'd0, 1'b1, 1'b1, 32'sd16384, 32'sd16384,
        16'sd32767, 16'sd6000}, 1'b0, '0},
    // failed gates break the chain
    '{'{pac_pkg::FUNC_INGEST, 63'd6000, 2'd0, 1'b0, 1'b1, 32'sd0, 32'sd0, 16'sd0, 16'sd0},
      1'b0, '0},
    '{'{pac_pkg::FUNC_INGEST, 63'd7000, 2'd0, 1'b1, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0},
      1'b0, '0},
    // position and rotation extremes, zero rotation, half turn
    '{'{pac_pkg::FUNC_INGEST, 63'd8000, 2'd0, 1'b1, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000,
        16'sh8000, 16'sh8000}, 1'b0, '0},
    '{'{pac_pkg::FUNC_INGEST, 63'd9000, 2'd0, 1'b1, 1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF,
        16'sd0, 16'sd0}, 1'b0, '0},
    '{'{pac_pkg::FUNC_INGEST, 63'd10000, 2'd0, 1'b1, 1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF,
        16'sh8000, 16'sd0}, 1'b0, '0},
    // one past the attempt window
    '{'{pac_pkg::FUNC_INGEST, 63'd10000001001, 2'd0, 1'b1, 1'b1, 32'sd0, 32'sd0, 16'shFFFF,
        16'sd32767}, 1'b0, '0},
    // clock change restarts the first stamp, then yaw agreement across the wrap
    '{'{pac_pkg::FUNC_INGEST, 63'd500, 2'd3, 1'b1, 1'b1, 32'sd0, 32'sd0, 16'sd32767, 16'sd1},
      1'b0, '0},
    '{'{pac_pkg::FUNC_INGEST, 63'h7FFF_FFFF_FFFF_FFFF, 2'd3, 1'b1, 1'b1, 32'sd0, 32'sd0,
        16'sd32767, 16'sd1}, 1'b0, '0},
    '{'{pac_pkg::FUNC_INGEST, 63'h7FFF_FFFF_FFFF_FFFF, 2'd3, 1'b1, 1'b1, 32'sd0, 32'sd0,
        16'sd32767, 16'shFFFF}, 1'b0, '0},
    '{'{pac_pkg::FUNC_QUERY, 63'h7FFF_FFFF_FFFF_FFFF, 2'd3, 1'b1, 1'b1, 32'sd0, 32'sd0,
        16'sd0, 16'sd0}, 1'b0, '0},
    '{'{pac_pkg::FUNC_CLEAR, 63'd77, 2'd2, 1'b1, 1'b1, 32'sd5, 32'sd5, 16'sd5, 16'sd5},
      1'b1, '{pac_pkg::OUT_SKIPPED, 1'b0, 32'd0, 16'd0}},
    '{'{pac_pkg::FUNC_QUERY, 63'd1, 2'd1, 1'b0, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0},
      1'b1, '{pac_pkg::OUT_SKIPPED, 1'b1, 32'd0, 16'd0}},
    '{'{pac_pkg::FUNC_INGEST, 63'd1, 2'd1, 1'b1, 1'b1, 32'shFFFF_FFFF, 32'shFFFF_FFFF,
        16'sd32767, 16'sd32767}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] func = '0;
  logic [62:0] now_ns = '0;
  logic [1:0] clock_kind = '0;
  logic status_pending = 1'b0;
  logic pose_finite = 1'b0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [15:0] rot_cos = '0;
  logic signed [15:0] rot_sin = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [1:0] outcome;
  logic probe_due;
  logic [31:0] probes_seen;
  logic [15:0] agreements;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [pac_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pose_agreement_confirmer dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of the settings and the confirmer state
  longint unsigned need_cfg, xy_cfg, yaw_cfg, period_cfg, window_cfg;
  logic [31:0] seen_cnt;
  logic [15:0] run_len;
  bit have_pose;
  logic signed [31:0] ref_x, ref_y;
  logic [15:0] ref_yaw;
  logic [62:0] first_ns, last_ns;
  logic [1:0] first_ck, last_ck;

  // stimulus generator state
  bit calm = 1'b0;
  logic [62:0] clock_ns;
  logic [1:0] ck_now;
  logic signed [31:0] base_x, base_y;
  logic signed [15:0] base_c, base_s;

  verdict_t verdict_q [$];
  verdict_t front;
  int mismatches = 0;

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    if (mismatches < 100)
      $display("%0t mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void wipe_history();
    seen_cnt = '0;
    run_len = '0;
    have_pose = 1'b0;
    ref_x = '0;
    ref_y = '0;
    ref_yaw = '0;
    first_ns = '0;
    last_ns = '0;
    first_ck = '0;
    last_ck = '0;
  endfunction

  // vectoring cordic, heading in 1/65536 turn with half-up rounding
  function automatic logic [15:0] cordic_heading(input logic signed [15:0] c,
                                                 input logic signed [15:0] s);
    longint x, y, xs, ys;
    logic [31:0] acc;
    int i;
    if (c == 0 && s == 0) return '0;
    x = longint'(c) * 65536;
    y = longint'(s) * 65536;
    acc = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 32'h8000_0000;
    end
    for (i = 0; i < pac_pkg::CORDIC_STAGES_DEF; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        acc = acc + ARCTAN_STEP[i];
      end else begin
        x = x - ys;
        y = y + xs;
        acc = acc - ARCTAN_STEP[i];
      end
    end
    acc = acc + 32'h0000_8000;
    return acc[31:16];
  endfunction

  function automatic bit pose_matches(input logic signed [31:0] px,
                                      input logic signed [31:0] py,
                                      input logic [15:0] heading);
    longint dx, dy;
    longint unsigned ax, ay;
    logic [15:0] d;
    dx = longint'(ref_x) - longint'(px);
    dy = longint'(ref_y) - longint'(py);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax > xy_cfg || ay > xy_cfg) return 1'b0;
    if (ax * ax + ay * ay > xy_cfg * xy_cfg) return 1'b0;
    d = heading - ref_yaw;
    if (d > 16'h8000) d = -d;
    return d <= yaw_cfg;
  endfunction

  function automatic verdict_t confirm_step(input pose_item_t it);
    verdict_t v;
    logic [15:0] heading;
    bit ok;
    ok = need_cfg != 0 && xy_cfg != 0 && yaw_cfg != 0 && period_cfg != 0 &&
         window_cfg != 0;
    v.verdict = pac_pkg::OUT_SKIPPED;
    v.due = 1'b0;
    case (it.func)
      pac_pkg::FUNC_QUERY: begin
        if (ok && it.now_ns != 0)
          v.due = last_ns == 0 || it.clock_kind != last_ck || it.now_ns < last_ns ||
                  (it.now_ns - last_ns) >= period_cfg;
      end
      pac_pkg::FUNC_INGEST: begin
        if (ok) begin
          if (seen_cnt != '1) seen_cnt++;
          if (first_ns == 0 || it.clock_kind != first_ck) begin
            first_ns = it.now_ns;
            first_ck = it.clock_kind;
          end
          last_ns = it.now_ns;
          last_ck = it.clock_kind;
          if (!(it.status_pending && it.pose_finite)) begin
            run_len = '0;
            have_pose = 1'b0;
          end else begin
            heading = cordic_heading(it.rot_cos, it.rot_sin);
            if (have_pose && pose_matches(it.pos_x, it.pos_y, heading)) begin
              if (run_len != '1) run_len++;
            end else begin
              run_len = 16'd1;
              have_pose = 1'b1;
            end
            ref_x = it.pos_x;
            ref_y = it.pos_y;
            ref_yaw = heading;
          end
          if (run_len >= need_cfg)
            v.verdict = pac_pkg::OUT_CONFIRMED;
          else if (it.clock_kind == first_ck && it.now_ns > first_ns &&
                   (it.now_ns - first_ns) > window_cfg)
            v.verdict = pac_pkg::OUT_TIMEOUT;
          else
            v.verdict = pac_pkg::OUT_PENDING;
        end
      end
      pac_pkg::FUNC_CLEAR: wipe_history();
      default: ;
    endcase
    v.seen = seen_cnt;
    v.run = run_len;
    return v;
  endfunction

  function automatic logic signed [15:0] clamp16(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // mostly well-formed probe sequences around a base pose, some pure noise
  function automatic pose_item_t draw_item();
    pose_item_t it;
    longint unsigned hop;
    longint span, jit;
    int r;
    if ($urandom_range(0, 99) < 25) begin
      it.func = 2'($urandom_range(0, 3));
      it.now_ns = 63'({$urandom, $urandom});
      it.clock_kind = 2'($urandom);
      it.status_pending = 1'($urandom);
      it.pose_finite = 1'($urandom);
      it.pos_x = $urandom;
      it.pos_y = $urandom;
      it.rot_cos = 16'($urandom);
      it.rot_sin = 16'($urandom);
      return it;
    end
    if ($urandom_range(0, 19) == 0) ck_now = 2'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      base_x = $urandom;
      base_y = $urandom;
      base_c = 16'($urandom);
      base_s = 16'($urandom);
    end
    hop = 0;
    case ($urandom_range(0, 10))
      0, 1, 2, 3: hop = 64'($urandom_range(0, 100));
      4, 5, 6: hop = period_cfg + 64'($urandom_range(0, 2)) - 64'd1;
      7: hop = {$urandom, $urandom} % (window_cfg + 1);
      8: hop = window_cfg + 64'($urandom_range(0, 2)) - 64'd1;
      // land right around the end of the attempt window
      9: clock_ns = 63'(first_ns + window_cfg + $urandom_range(0, 2) - 1);
      default: hop = {$urandom, $urandom} >> $urandom_range(1, 40);
    endcase
    clock_ns = 63'(clock_ns + hop);
    r = $urandom_range(0, 99);
    it.func = (r < 68) ? pac_pkg::FUNC_INGEST : (r < 93) ? pac_pkg::FUNC_QUERY :
              (r < 96) ? pac_pkg::FUNC_CLEAR : FUNC_UNUSED;
    it.now_ns = ($urandom_range(0, 49) == 0) ? 63'd0 : clock_ns;
    it.clock_kind = ck_now;
    it.status_pending = $urandom_range(0, 9) != 0;
    it.pose_finite = $urandom_range(0, 9) != 0;
    span = (xy_cfg > (64'd1 << 29)) ? (longint'(1) << 29) : longint'(xy_cfg + xy_cfg / 4 + 1);
    jit = longint'($urandom_range(0, 32'(2 * span))) - span;
    it.pos_x = 32'(longint'(base_x) + jit);
    jit = longint'($urandom_range(0, 32'(2 * span))) - span;
    it.pos_y = 32'(longint'(base_y) + jit);
    span = (yaw_cfg > 3000) ? 12000 : longint'(4 * yaw_cfg + 4);
    it.rot_cos = clamp16(int'(base_c) + int'($urandom_range(0, 32'(2 * span))) - int'(span));
    it.rot_sin = clamp16(int'(base_s) + int'($urandom_range(0, 32'(2 * span))) - int'(span));
    return it;
  endfunction

  task automatic push_transaction(input pose_item_t it, input bit typed,
                                  input verdict_t want);
    verdict_t forecast;
    while (!calm && $urandom_range(0, 99) < 11) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    func <= it.func;
    now_ns <= it.now_ns;
    clock_kind <= it.clock_kind;
    status_pending <= it.status_pending;
    pose_finite <= it.pose_finite;
    pos_x <= it.pos_x;
    pos_y <= it.pos_y;
    rot_cos <= it.rot_cos;
    rot_sin <= it.rot_sin;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    forecast = confirm_step(it);
    verdict_q.push_back(typed ? want : forecast);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [39:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      pac_pkg::REG_FRAMES: need_cfg = 64'(val[15:0]);
      pac_pkg::REG_XY_TOL: xy_cfg = 64'(val[30:0]);
      pac_pkg::REG_YAW_TOL: yaw_cfg = 64'(val[14:0]);
      pac_pkg::REG_PERIOD: period_cfg = 64'(val);
      pac_pkg::REG_WINDOW: window_cfg = 64'(val);
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int ph);
    logic [39:0] v [5];
    int i;
    case (ph)
      0: v = '{40'd3, 40'd65536, 40'd1000, 40'd1000, 40'd20000};
      1: v = '{40'hFFFF, 40'h7FFF_FFFF, 40'h7FFF, REG40_MAX, REG40_MAX};
      2: v = '{40'd1, 40'd1, 40'd1, 40'd1, 40'd1};
      default: begin
        v[0] = 40'($urandom_range(1, 6));
        v[1] = 40'($urandom_range(1, 1 << 22));
        v[2] = 40'($urandom_range(1, 3000));
        v[3] = 40'($urandom_range(1, 1000000));
        v[4] = v[3] * 40'($urandom_range(1, 20));
        // a zero register makes the settings invalid
        if (ph % 3 == 1) v[$urandom_range(0, 4)] = '0;
        // bits above the register width must be dropped
        if (ph == 5 || ph == 9)
          for (i = 0; i < 5; i++)
            v[i] = v[i] | 40'({$urandom, $urandom} << REG_WIDTH[i]);
      end
    endcase
    set_reg(pac_pkg::REG_FRAMES, v[0]);
    set_reg(pac_pkg::REG_XY_TOL, v[1]);
    set_reg(pac_pkg::REG_YAW_TOL, v[2]);
    set_reg(pac_pkg::REG_PERIOD, v[3]);
    set_reg(pac_pkg::REG_WINDOW, v[4]);
    set_reg(REG_SPARE, 40'({$urandom, $urandom}));
    cfg_write <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch("result with nothing expected", outcome, 0);
        end else begin
          front = verdict_q.pop_front();
          if (outcome !== front.verdict) flag_mismatch("outcome", outcome, front.verdict);
          if (probe_due !== front.due) flag_mismatch("probe_due", probe_due, front.due);
          if (probes_seen !== front.seen) flag_mismatch("probes_seen", probes_seen, front.seen);
          if (agreements !== front.run) flag_mismatch("agreements", agreements, front.run);
        end
      end
      result_stall <= !calm && $urandom_range(0, 99) < 11;
    end
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int ph, n, k;
    need_cfg = 3;
    xy_cfg = 16384;
    yaw_cfg = 910;
    period_cfg = 64'd1000000000;
    window_cfg = 64'd10000000000;
    wipe_history();
    clock_ns = '0;
    ck_now = '0;
    base_x = '0;
    base_y = '0;
    base_c = 16'sd32767;
    base_s = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (k = 0; k < $size(PLAN); k++)
      push_transaction(PLAN[k].stim, PLAN[k].typed, PLAN[k].want);
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      apply_settings(ph);
      calm = (ph == 3);
      ck_now = 2'($urandom);
      for (n = 0; n < PHASE_ITEMS; n++)
        push_transaction(draw_item(), 1'b0, '0);
    end
    calm = 1'b0;
    drain();
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
